### sv/albpd_pkg.sv
// Shared types and constants for the ADC ladder button press decoder.
`timescale 1ns / 1ps

package albpd_pkg;

    // Fixed field widths
    localparam int CFG_W  = 12;
    localparam int TIME_W = 32;
    localparam int TICK_W = 7;
    localparam int CODE_W = 3;
    localparam int EVT_W  = 4;
    localparam int PH_W   = 3;
    localparam int OUT_W  = 8;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_RELEASE_LEVEL = 3'd0;
    localparam logic [IDX_W-1:0] REG_NONE_BAND_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_ESC_BAND_MAX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_UP_BAND_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOWN_BAND_MAX = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLDOFF_MS    = 3'd5;

    // Button codes
    localparam logic [CODE_W-1:0] BTN_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] BTN_ESC   = 3'd1;
    localparam logic [CODE_W-1:0] BTN_UP    = 3'd2;
    localparam logic [CODE_W-1:0] BTN_DOWN  = 3'd3;
    localparam logic [CODE_W-1:0] BTN_ENTER = 3'd4;

    // Event codes
    localparam logic [EVT_W-1:0] EVT_NONE    = 4'd0;
    localparam logic [EVT_W-1:0] LONG_OFFSET = 4'd4;

    // Tick counter limits
    localparam logic [TICK_W-1:0] TICK_MAX      = 7'd127;
    localparam logic [TICK_W-1:0] SHORT_SAMPLES = 7'd40;
    localparam logic [TICK_W-1:0] LONG_CHECK    = 7'd21;
    localparam logic [TICK_W-1:0] LONG_REPEAT   = 7'd100;
    localparam logic [TICK_W-1:0] CALM_TICKS    = 7'd20;

    // Configuration reset values
    localparam logic [CFG_W-1:0]  RST_RELEASE_LEVEL = 12'd400;
    localparam logic [CFG_W-1:0]  RST_NONE_BAND_MAX = 12'd400;
    localparam logic [CFG_W-1:0]  RST_ESC_BAND_MAX  = 12'd1200;
    localparam logic [CFG_W-1:0]  RST_UP_BAND_MAX   = 12'd2000;
    localparam logic [CFG_W-1:0]  RST_DOWN_BAND_MAX = 12'd2900;
    localparam logic [TIME_W-1:0] RST_HOLDOFF_MS    = 32'd0;

    typedef enum logic [PH_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_SHORT = 3'd1,
        PH_LONG  = 3'd2,
        PH_CALM  = 3'd3,
        PH_WAIT  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0]  release_level;
        logic [CFG_W-1:0]  none_band_max;
        logic [CFG_W-1:0]  esc_band_max;
        logic [CFG_W-1:0]  up_band_max;
        logic [CFG_W-1:0]  down_band_max;
        logic [TIME_W-1:0] holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic [EVT_W-1:0] press_event;
        phase_t           phase;
    } step_res_t;

endpackage

### sv/albpd_smooth.sv
// Sample smoother: level = (2*level + sample) / 3, divide by reciprocal multiply.
`timescale 1ns / 1ps

module albpd_smooth import albpd_pkg::*; #(
    parameter int ADC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [ADC_BITS-1:0] sample,
    output logic [ADC_BITS-1:0] level_next
);

    localparam int VW = ADC_BITS + 2;
    localparam logic [VW-1:0] RECIP = VW'((2 ** VW) / 3);
    localparam logic [VW-1:0] THREE = VW'(3);

    logic [ADC_BITS-1:0] level_reg;
    logic [VW-1:0]       sum;
    logic [2*VW-1:0]     prod;
    logic [VW-1:0]       quot_est;
    logic [VW-1:0]       three_q;
    logic [VW-1:0]       rem;
    logic [VW-1:0]       quot;

    // Form 2*level + sample
    assign sum = {1'b0, level_reg, 1'b0} + VW'(sample);

    // Estimate quotient, low by at most one
    assign prod     = (2 * VW)'(sum) * (2 * VW)'(RECIP);
    assign quot_est = prod[2*VW-1:VW];

    // Correct with one compare
    assign three_q    = {quot_est[VW-2:0], 1'b0} + quot_est;
    assign rem        = sum - three_q;
    assign quot       = quot_est + VW'(rem >= THREE);
    assign level_next = quot[ADC_BITS-1:0];

    // Hold smoothed level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (step)
        begin
            level_reg <= level_next;
        end
    end

endmodule

### sv/albpd_fsm.sv
// Press phase machine: band decode, tick counter, hold-off timer.
`timescale 1ns / 1ps

module albpd_fsm import albpd_pkg::*; #(
    parameter int ADC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [ADC_BITS-1:0] sample,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic                mark_holdoff,
    input  logic [ADC_BITS-1:0] level,
    input  cfg_t                cfg,
    output step_res_t           res
);

    localparam int CMP_W = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CODE_W-1:0]   short_reg, short_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic [TICK_W-1:0]   tick_inc;
    logic [TIME_W-1:0]   elapsed;
    logic [CMP_W-1:0]    sample_x, level_x, release_x;
    logic [CODE_W-1:0]   band;
    logic                released;
    logic [EVT_W-1:0]    press_event;

    assign sample_x  = CMP_W'(sample);
    assign level_x   = CMP_W'(level);
    assign release_x = CMP_W'(cfg.release_level);
    assign released  = (sample_x <= release_x);

    // Decode raw sample into a button band, first edge wins
    always_comb
    begin
        priority if (sample_x <= CMP_W'(cfg.none_band_max)) band = BTN_NONE;
        else if (sample_x <= CMP_W'(cfg.esc_band_max))      band = BTN_ESC;
        else if (sample_x <= CMP_W'(cfg.up_band_max))       band = BTN_UP;
        else if (sample_x <= CMP_W'(cfg.down_band_max))     band = BTN_DOWN;
        else                                                band = BTN_ENTER;
    end

    // Saturating tick advance
    assign tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 7'd1;

    // Take the new mark before measuring the hold-off window
    assign mark_next = mark_holdoff ? now_ms : mark_reg;
    assign elapsed   = now_ms - mark_next;

    // Next phase and event
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        short_next  = short_reg;
        press_event = EVT_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                priority if (elapsed < cfg.holdoff_ms)
                begin
                    phase_next = PH_CALM;
                end
                else if (level_x > release_x)
                begin
                    phase_next = PH_SHORT;
                    tick_next  = '0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SHORT:
            begin
                short_next = band;
                tick_next  = tick_inc;
                if (tick_inc == SHORT_SAMPLES)
                begin
                    tick_next = '0;
                    if (band != BTN_NONE)
                    begin
                        press_event = EVT_W'(band);
                        phase_next  = PH_LONG;
                    end
                    else
                    begin
                        phase_next = PH_CALM;
                    end
                end
            end
            PH_LONG:
            begin
                priority if (tick_inc == LONG_CHECK && band != short_reg)
                begin
                    tick_next  = '0;
                    phase_next = PH_CALM;
                end
                else if (tick_inc == LONG_REPEAT)
                begin
                    tick_next = '0;
                    if (band == short_reg)
                    begin
                        press_event = EVT_W'(short_reg) + LONG_OFFSET;
                    end
                    else
                    begin
                        phase_next = PH_CALM;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_CALM:
            begin
                short_next = BTN_NONE;
                tick_next  = '0;
                phase_next = released ? PH_IDLE : PH_WAIT;
            end
            PH_WAIT:
            begin
                tick_next = tick_inc;
                if (tick_inc > CALM_TICKS && released)
                begin
                    tick_next  = '0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res.press_event = press_event;
    assign res.phase       = phase_next;

    // Hold machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            short_reg <= BTN_NONE;
            mark_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            short_reg <= short_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

### sv/adc_ladder_button_press_decoder_unit.sv
// Top level: stream ports, configuration registers, input and result registers.
`timescale 1ns / 1ps

// Decodes button presses on a resistor-ladder ADC input. Each input word is one
// poll tick and yields exactly one result word (press event and phase after the
// tick). A word can be taken every cycle while the result side is not stalled; its
// result passes the input register, then the result register. The clock is
// bounded by the per-tick feedback loop: the smoother's reciprocal multiply feeding
// the idle-phase level compare and the phase register. Configuration writes are
// always taken; the user must keep them to idle periods, as the block does not check.
module adc_ladder_button_press_decoder_unit import albpd_pkg::*; #(
    parameter  int ADC_BITS = 12,
    localparam int IN_W     = ((ADC_BITS + TIME_W + 1 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // adc_sample [ADC_BITS-1:0], now_ms [32], mark_holdoff [1], zero pad
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // press_event [3:0], phase [6:4], zero pad [7]
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [TIME_W-1:0]   cfg_data
);

    cfg_t                cfg_reg;
    logic                in_vld_reg;
    logic [ADC_BITS-1:0] in_sample_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic                in_mark_reg;
    logic                out_vld_reg;
    step_res_t           out_res_reg;
    logic                advance;
    logic [ADC_BITS-1:0] level_next;
    step_res_t           res;

    // Move a word to the result register when it is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_level <= RST_RELEASE_LEVEL;
            cfg_reg.none_band_max <= RST_NONE_BAND_MAX;
            cfg_reg.esc_band_max  <= RST_ESC_BAND_MAX;
            cfg_reg.up_band_max   <= RST_UP_BAND_MAX;
            cfg_reg.down_band_max <= RST_DOWN_BAND_MAX;
            cfg_reg.holdoff_ms    <= RST_HOLDOFF_MS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RELEASE_LEVEL: cfg_reg.release_level <= cfg_data[CFG_W-1:0];
                REG_NONE_BAND_MAX: cfg_reg.none_band_max <= cfg_data[CFG_W-1:0];
                REG_ESC_BAND_MAX:  cfg_reg.esc_band_max  <= cfg_data[CFG_W-1:0];
                REG_UP_BAND_MAX:   cfg_reg.up_band_max   <= cfg_data[CFG_W-1:0];
                REG_DOWN_BAND_MAX: cfg_reg.down_band_max <= cfg_data[CFG_W-1:0];
                REG_HOLDOFF_MS:    cfg_reg.holdoff_ms    <= cfg_data;
                default:           cfg_reg.holdoff_ms    <= cfg_reg.holdoff_ms;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Capture input word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= s_tdata[ADC_BITS-1:0];
            in_now_reg    <= s_tdata[ADC_BITS +: TIME_W];
            in_mark_reg   <= s_tdata[ADC_BITS + TIME_W];
        end
    end

    albpd_smooth #(
        .ADC_BITS (ADC_BITS)
    ) u_smooth (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .sample     (in_sample_reg),
        .level_next (level_next)
    );

    albpd_fsm #(
        .ADC_BITS (ADC_BITS)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .sample       (in_sample_reg),
        .now_ms       (in_now_reg),
        .mark_holdoff (in_mark_reg),
        .level        (level_next),
        .cfg          (cfg_reg),
        .res          (res)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Capture result word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_res_reg.phase, out_res_reg.press_event};

endmodule

### sv/albpd_checker.sv
// Port-level checker for the press decoder, bound to the top level.
`timescale 1ns / 1ps

module albpd_checker import albpd_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

    // Event code stays within short and long codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= (EVT_W'(BTN_ENTER) + LONG_OFFSET))
    else $error("press event code out of range");

    // Phase code stays within the five phases
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:4] <= PH_WAIT)
    else $error("phase code out of range");

    // Any press event leaves the machine in long hold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] != EVT_NONE) |-> m_tdata[6:4] == PH_LONG)
    else $error("press event outside long hold");

endmodule

bind adc_ladder_button_press_decoder_unit albpd_checker u_albpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/tb_top.sv
// Self-checking testbench for the ADC ladder button press decoder unit.
`timescale 1ns / 1ps

module tb_top;
    import albpd_pkg::*;

    localparam int ADC_W     = 12;
    localparam int IN_W      = ((ADC_W + TIME_W + 1 + 7) / 8) * 8;
    localparam int RUN_LIMIT = 500000;
    localparam int TAIL_WAIT = 6;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [TIME_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and state
    cfg_t              dec_cfg;
    phase_t            dec_phase;
    logic [ADC_W-1:0]  dec_level;
    logic [TICK_W-1:0] dec_ticks;
    logic [CODE_W-1:0] dec_short;
    logic [CODE_W-1:0] dec_long;
    logic [TIME_W-1:0] dec_mark;

    step_res_t         pending_results[$];
    int                mismatches   = 0;
    int                items_sent   = 0;
    int                cycles       = 0;
    int                tx_idle_pct  = 0;
    int                rx_idle_pct  = 0;
    int                rx_hold_left = 0;
    int                rx_hold_len  = 0;
    int                rx_hold_reqs = 0;
    int                rx_hold_seen = 0;
    int                mark_permille = 5;
    logic [TIME_W-1:0] clock_ms     = '0;

    adc_ladder_button_press_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("FAIL adc_ladder_button_press_decoder_unit");
            $finish;
        end
    end

    // Map a raw sample onto a button band; first matching edge wins
    function automatic logic [CODE_W-1:0] decode_band(logic [ADC_W-1:0] raw);
        if (raw <= dec_cfg.none_band_max) return BTN_NONE;
        if (raw <= dec_cfg.esc_band_max)  return BTN_ESC;
        if (raw <= dec_cfg.up_band_max)   return BTN_UP;
        if (raw <= dec_cfg.down_band_max) return BTN_DOWN;
        return BTN_ENTER;
    endfunction

    function automatic void bump_ticks();
        if (dec_ticks < TICK_MAX) dec_ticks++;
    endfunction

    // Advance the press machine by one poll tick and return the result word
    function automatic step_res_t advance_decoder(logic [ADC_W-1:0] raw,
                                                  logic [TIME_W-1:0] now, logic mark);
        step_res_t         res;
        logic [EVT_W-1:0]  evt;
        logic [ADC_W+1:0]  acc;
        evt = EVT_NONE;
        if (mark) dec_mark = now;
        acc = ({2'b00, dec_level} << 1) + {2'b00, raw};
        dec_level = ADC_W'(acc / 3);
        case (dec_phase)
            PH_IDLE:
            begin
                if (TIME_W'(now - dec_mark) < dec_cfg.holdoff_ms)
                    dec_phase = PH_CALM;
                else if (dec_level > dec_cfg.release_level)
                begin
                    dec_phase = PH_SHORT;
                    dec_ticks = '0;
                end
            end
            PH_SHORT:
            begin
                dec_short = decode_band(raw);
                bump_ticks();
                if (dec_ticks == SHORT_SAMPLES)
                begin
                    if (dec_short != BTN_NONE)
                    begin
                        evt = EVT_W'(dec_short);
                        dec_phase = PH_LONG;
                    end
                    else
                        dec_phase = PH_CALM;
                    dec_ticks = '0;
                end
            end
            PH_LONG:
            begin
                bump_ticks();
                dec_long = decode_band(raw);
                if (dec_ticks == LONG_CHECK && dec_long != dec_short)
                begin
                    dec_ticks = '0;
                    dec_phase = PH_CALM;
                end
                if (dec_ticks == LONG_REPEAT)
                begin
                    if (dec_long == dec_short)
                        evt = EVT_W'(dec_short) + LONG_OFFSET;
                    else
                        dec_phase = PH_CALM;
                    dec_ticks = '0;
                end
            end
            PH_CALM:
            begin
                dec_long  = BTN_NONE;
                dec_short = BTN_NONE;
                dec_ticks = '0;
                dec_phase = (raw <= dec_cfg.release_level) ? PH_IDLE : PH_WAIT;
            end
            PH_WAIT:
            begin
                bump_ticks();
                if (dec_ticks > CALM_TICKS && raw <= dec_cfg.release_level)
                begin
                    dec_ticks = '0;
                    dec_phase = PH_IDLE;
                end
            end
            default: dec_phase = PH_IDLE;
        endcase
        res.press_event = evt;
        res.phase       = dec_phase;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int wanted);
        mismatches++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, wanted);
    endtask

    // Compare one result word with the oldest expectation
    task automatic check_result(logic [OUT_W-1:0] word);
        step_res_t wanted;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result word with nothing pending, phase", int'(word[6:4]), -1);
            return;
        end
        wanted = pending_results.pop_front();
        if (word[3:0] !== wanted.press_event)
            report_mismatch("press_event", int'(word[3:0]), int'(wanted.press_event));
        if (word[6:4] !== wanted.phase)
            report_mismatch("phase", int'(word[6:4]), int'(wanted.phase));
        if (word[7] !== 1'b0)
            report_mismatch("pad bit", int'(word[7]), 0);
    endtask

    // Take result words and stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) check_result(m_tdata);
        m_tready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Start and count down a long receiver hold-off
    always @(posedge clk)
    begin
        if (rx_hold_reqs != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= rx_hold_len;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Offer one word and wait until it is taken
    task automatic send_tick(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] now,
                             input logic mark);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - ADC_W - TIME_W - 1){1'b0}}, mark, now, adc};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(advance_decoder(adc, now, mark));
        items_sent++;
    endtask

    // Advance the millisecond clock and send a sample
    task automatic next_tick(input logic [ADC_W-1:0] adc);
        clock_ms += TIME_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 1);
        send_tick(adc, clock_ms, $urandom_range(0, 999) < mark_permille);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Hold off the sender until every result is in, then let the pipe settle
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // Offer one register write and wait until it is taken; valid stays up
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_RELEASE_LEVEL: dec_cfg.release_level = val[CFG_W-1:0];
            REG_NONE_BAND_MAX: dec_cfg.none_band_max = val[CFG_W-1:0];
            REG_ESC_BAND_MAX:  dec_cfg.esc_band_max  = val[CFG_W-1:0];
            REG_UP_BAND_MAX:   dec_cfg.up_band_max   = val[CFG_W-1:0];
            REG_DOWN_BAND_MAX: dec_cfg.down_band_max = val[CFG_W-1:0];
            REG_HOLDOFF_MS:    dec_cfg.holdoff_ms    = val;
            default: ;
        endcase
    endtask

    // Reprogram every register; only called with the block idle
    task automatic set_config(input logic [CFG_W-1:0] rel, input logic [CFG_W-1:0] none_max,
                              input logic [CFG_W-1:0] esc_max, input logic [CFG_W-1:0] up_max,
                              input logic [CFG_W-1:0] down_max, input logic [TIME_W-1:0] hold);
        stop_sending();
        wait_drained();
        write_reg(REG_RELEASE_LEVEL, TIME_W'(rel));
        write_reg(REG_NONE_BAND_MAX, TIME_W'(none_max));
        write_reg(REG_ESC_BAND_MAX,  TIME_W'(esc_max));
        write_reg(REG_UP_BAND_MAX,   TIME_W'(up_max));
        write_reg(REG_DOWN_BAND_MAX, TIME_W'(down_max));
        write_reg(REG_HOLDOFF_MS,    hold);
        cfg_valid <= 1'b0;
    endtask

    // Pick a sample inside a button band, or anywhere when the band is empty
    function automatic logic [ADC_W-1:0] level_for(logic [CODE_W-1:0] btn);
        int edges[5];
        int lo;
        int hi;
        edges = '{int'(dec_cfg.none_band_max), int'(dec_cfg.esc_band_max),
                  int'(dec_cfg.up_band_max), int'(dec_cfg.down_band_max), 4095};
        lo = 0;
        if (btn != BTN_NONE) lo = edges[btn - 1] + 1;
        hi = edges[btn];
        if (lo > hi) return ADC_W'($urandom_range(0, 4095));
        return ADC_W'($urandom_range(lo, hi));
    endfunction

    // Hold one button with the odd glitch sample
    task automatic hold_button(input logic [CODE_W-1:0] btn, input int ticks);
        repeat (ticks)
        begin
            if ($urandom_range(0, 99) < 3) next_tick(ADC_W'($urandom_range(0, 4095)));
            else next_tick(level_for(btn));
        end
    endtask

    task automatic release_buttons(input int ticks);
        repeat (ticks)
        begin
            if ($urandom_range(0, 99) < 3) next_tick(ADC_W'($urandom_range(0, 4095)));
            else next_tick(ADC_W'($urandom_range(0, dec_cfg.release_level)));
        end
    endtask

    // One press: short, long, changing button, no-button band, or noise
    task automatic press_episode();
        logic [CODE_W-1:0] btn;
        logic [CODE_W-1:0] other;
        int                kind;
        kind  = $urandom_range(0, 99);
        btn   = CODE_W'($urandom_range(BTN_ESC, BTN_ENTER));
        other = (btn == BTN_ENTER) ? BTN_ESC : btn + 1'b1;
        if (kind < 35)
            hold_button(btn, $urandom_range(38, 70));
        else if (kind < 60)
            hold_button(btn, $urandom_range(100, 330));
        else if (kind < 78)
        begin
            // switch buttons mid-press; a long tail parks the calm wait counter
            hold_button(btn, $urandom_range(30, 60));
            hold_button(other, $urandom_range(10, 200));
        end
        else if (kind < 86)
            hold_button(BTN_NONE, $urandom_range(40, 60));
        else
            repeat ($urandom_range(5, 40)) next_tick(ADC_W'($urandom_range(0, 4095)));
        release_buttons($urandom_range(20, 45));
    endtask

    task automatic run_presses(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target) press_episode();
    endtask

    // Drive the corner values of every input field
    task automatic test_field_extremes();
        send_tick(12'h000, 32'h0000_0000, 1'b0);
        send_tick(12'hFFF, 32'hFFFF_FFFF, 1'b1);
        send_tick(12'hFFF, 32'h0000_0000, 1'b0);
        send_tick(12'h555, 32'h5555_5555, 1'b1);
        send_tick(12'hAAA, 32'hAAAA_AAAA, 1'b0);
        send_tick(12'hFFF, 32'hAAAA_AAAB, 1'b0);
        send_tick(12'h000, 32'hFFFF_FFFF, 1'b1);
        send_tick(12'h190, 32'h0000_0001, 1'b0);
        send_tick(12'h191, 32'h0000_0002, 1'b0);
        send_tick(12'h4B0, 32'h0000_0003, 1'b0);
        send_tick(12'h4B1, 32'h0000_0004, 1'b0);
        send_tick(12'h7D0, 32'h0000_0005, 1'b0);
        send_tick(12'h7D1, 32'h0000_0006, 1'b0);
        send_tick(12'hB54, 32'h0000_0007, 1'b0);
        send_tick(12'hB55, 32'h0000_0008, 1'b0);
        send_tick(12'h000, 32'h0000_0009, 1'b0);
        clock_ms = 32'h0000_0100;
    endtask

    task automatic test_default_presses();
        run_presses(240);
    endtask

    // Short window after marks, with the clock crossing its wrap
    task automatic test_holdoff_window();
        set_config(12'd600, 12'd500, 12'd1300, 12'd2200, 12'd3100, 32'd30);
        clock_ms      = 32'hFFFF_FE00;
        mark_permille = 30;
        run_presses(240);
        mark_permille = 5;
    endtask

    task automatic test_edge_bands();
        set_config(12'd0, 12'd0, 12'd1365, 12'd2730, 12'd4094, 32'd0);
        clock_ms = TIME_W'($urandom());
        run_presses(120);
    endtask

    task automatic test_unordered_bands();
        set_config(12'd1000, 12'd3000, 12'd1500, 12'd4095, 12'd0, 32'd7);
        run_presses(90);
    endtask

    // Nothing counts as pressed and every tick sits in the hold-off window
    task automatic test_ceilings();
        set_config(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        mark_permille = 50;
        run_presses(40);
        mark_permille = 5;
    endtask

    // Stall the result side long enough for the input to back up
    task automatic test_backpressure();
        set_config(RST_RELEASE_LEVEL, RST_NONE_BAND_MAX, RST_ESC_BAND_MAX,
                   RST_UP_BAND_MAX, RST_DOWN_BAND_MAX, RST_HOLDOFF_MS);
        rx_hold_len = 300;
        rx_hold_reqs++;
        hold_button(BTN_DOWN, 60);
        stop_sending();
        wait_drained();
        run_presses(70);
    endtask

    initial
    begin
        dec_cfg   = '{RST_RELEASE_LEVEL, RST_NONE_BAND_MAX, RST_ESC_BAND_MAX,
                      RST_UP_BAND_MAX, RST_DOWN_BAND_MAX, RST_HOLDOFF_MS};
        dec_phase = PH_IDLE;
        dec_level = '0;
        dec_ticks = '0;
        dec_short = BTN_NONE;
        dec_long  = BTN_NONE;
        dec_mark  = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 25;
        rx_idle_pct = 45;
        test_field_extremes();
        test_default_presses();

        tx_idle_pct = 45;
        rx_idle_pct = 25;
        test_holdoff_window();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_edge_bands();
        test_unordered_bands();
        test_ceilings();
        test_backpressure();

        stop_sending();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS adc_ladder_button_press_decoder_unit");
        else
            $display("FAIL adc_ladder_button_press_decoder_unit");
        $finish;
    end

endmodule
